@@ src/olst_pkg.sv @@
// Shared types, action codes and sizes for the ordered list engine.
package olst_pkg;

    localparam int LIST_DEPTH_DEF = 16;
    localparam int ENTRY_W        = 32;
    localparam int ACTION_W       = 2;
    localparam int RSP_COUNT_W    = 5;

    localparam logic [ACTION_W-1:0] ACT_INSERT       = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_REMOVE_FIRST = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_REMOVE_ALL   = 2'd2;
    localparam logic [ACTION_W-1:0] ACT_FIND         = 2'd3;

    typedef struct packed {
        logic [ACTION_W-1:0]       action;
        logic signed [ENTRY_W-1:0] value;
    } req_t;

    typedef struct packed {
        logic                   hit;
        logic [RSP_COUNT_W-1:0] count;
        logic                   overflow;
    } rsp_t;

    // Per-cycle command broadcast to every cell.
    typedef struct packed {
        logic push;   // shift one place back, key enters at the front
        logic pull;   // close the gap at the first match
    } cell_ctrl_t;

endpackage

@@ src/olst_cell.sv @@
// One list cell: holds an entry, compares it to the key, shifts with its neighbors.
module olst_cell
    import olst_pkg::*;
(
    input  logic                clk,
    input  cell_ctrl_t          ctrl,
    input  logic [ENTRY_W-1:0]  key,
    input  logic                occupied,
    input  logic [ENTRY_W-1:0]  prev_entry,
    input  logic [ENTRY_W-1:0]  next_entry,
    input  logic                seen_in,
    output logic [ENTRY_W-1:0]  entry,
    output logic                seen_out
);

    logic [ENTRY_W-1:0] entry_reg;
    logic [ENTRY_W-1:0] entry_next;
    logic               match;

    assign match    = occupied && (entry_reg == key);
    assign seen_out = seen_in || match;
    assign entry    = entry_reg;

    always_comb
    begin
        entry_next = entry_reg;
        if (ctrl.push)
        begin
            entry_next = prev_entry;
        end
        else if (ctrl.pull && seen_out)
        begin
            // take the neighbor behind from the first match onward
            entry_next = next_entry;
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

endmodule

@@ src/ordered_list_engine.sv @@
// Top level of the ordered list engine: cell chain, fill count and request control.
//
// Usage:
//   Requests arrive on req_valid / req_ready / req (action, value); results
//   leave on rsp_valid / rsp_ready / rsp (hit, count, overflow). Each request
//   gives exactly one result, in request order.
//   The list lives in a chain of LIST_DEPTH cells, front at cell 0. Every
//   cell compares its entry with the key at once; a match flag ripples back
//   along the chain so that only the frontmost match and the cells behind
//   it shift forward.
//   Insert, remove-first and find register their result in the cycle after
//   acceptance. Remove-all deletes one match per cycle through the same chain
//   and registers its result once no match is left, or at acceptance when
//   nothing matches.
//   A request is taken while no remove-all is in progress and the result
//   register is empty or being drained in the same cycle; a stalled
//   receiver therefore holds off new requests after one waiting result.
//   Reset empties the list (count zero) and drops any waiting result; cell
//   contents are not cleared since entries past the count are never read.
//   An insert into a full list is dropped and answered with overflow set.
//   The count field carries the low five bits of the fill count.
module ordered_list_engine
    import olst_pkg::*;
#(
    parameter int LIST_DEPTH = LIST_DEPTH_DEF
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic req_valid,
    output logic req_ready,
    input  req_t req,
    output logic rsp_valid,
    input  logic rsp_ready,
    output rsp_t rsp
);

    localparam int CNT_W = $clog2(LIST_DEPTH + 1);

    localparam logic ST_IDLE   = 1'b0;
    localparam logic ST_REMALL = 1'b1;

    logic               state_reg;
    logic               state_next;
    logic [CNT_W-1:0]   count_reg;
    logic [CNT_W-1:0]   count_next;
    logic [ENTRY_W-1:0] key_reg;
    logic [ENTRY_W-1:0] key_next;
    logic               rsp_valid_reg;
    logic               rsp_valid_next;
    rsp_t               rsp_reg;
    rsp_t               rsp_next;

    cell_ctrl_t         ctrl;
    logic [ENTRY_W-1:0] key;
    logic               accept;
    logic               full;
    logic               any_match;
    logic               load_rsp;
    logic               rsp_hit;
    logic               rsp_ovf;
    logic [CNT_W+RSP_COUNT_W-1:0] count_ext;

    logic [ENTRY_W-1:0] entry_w [LIST_DEPTH];
    logic [LIST_DEPTH:0] seen_w;

    // Cell chain: the match flag enters clear at the front and ripples back.
    assign seen_w[0] = 1'b0;

    genvar i;
    generate
        for (i = 0; i < LIST_DEPTH; i++)
        begin : g_cell
            logic [ENTRY_W-1:0] prev_e;
            logic [ENTRY_W-1:0] next_e;

            if (i == 0)
            begin : g_front
                assign prev_e = key;
            end
            else
            begin : g_mid_prev
                assign prev_e = entry_w[i-1];
            end

            if (i == LIST_DEPTH - 1)
            begin : g_back
                // the last slot becomes free after a pull; hold what it has
                assign next_e = entry_w[i];
            end
            else
            begin : g_mid_next
                assign next_e = entry_w[i+1];
            end

            olst_cell u_cell
            (
                .clk        (clk),
                .ctrl       (ctrl),
                .key        (key),
                .occupied   (count_reg > CNT_W'(i)),
                .prev_entry (prev_e),
                .next_entry (next_e),
                .seen_in    (seen_w[i]),
                .entry      (entry_w[i]),
                .seen_out   (seen_w[i+1])
            );
        end
    endgenerate

    assign any_match = seen_w[LIST_DEPTH];
    assign full      = (count_reg == CNT_W'(LIST_DEPTH));
    assign req_ready = (state_reg == ST_IDLE) && (!rsp_valid_reg || rsp_ready);
    assign accept    = req_valid && req_ready;
    // during remove-all the stored key drives the compare
    assign key       = (state_reg == ST_REMALL) ? key_reg : req.value;

    always_comb
    begin
        ctrl       = '0;
        count_next = count_reg;
        state_next = state_reg;
        key_next   = key_reg;
        load_rsp   = 1'b0;
        rsp_hit    = 1'b0;
        rsp_ovf    = 1'b0;

        if (state_reg == ST_IDLE)
        begin
            if (accept)
            begin
                case (req.action)
                    ACT_INSERT:
                    begin
                        load_rsp = 1'b1;
                        if (full)
                        begin
                            // drop the value, flag overflow
                            rsp_ovf = 1'b1;
                        end
                        else
                        begin
                            ctrl.push  = 1'b1;
                            count_next = count_reg + CNT_W'(1);
                            rsp_hit    = 1'b1;
                        end
                    end
                    ACT_REMOVE_FIRST:
                    begin
                        load_rsp = 1'b1;
                        rsp_hit  = any_match;
                        if (any_match)
                        begin
                            ctrl.pull  = 1'b1;
                            count_next = count_reg - CNT_W'(1);
                        end
                    end
                    ACT_REMOVE_ALL:
                    begin
                        if (any_match)
                        begin
                            // remove the first match now, the rest one per cycle
                            ctrl.pull  = 1'b1;
                            count_next = count_reg - CNT_W'(1);
                            key_next   = req.value;
                            state_next = ST_REMALL;
                        end
                        else
                        begin
                            load_rsp = 1'b1;
                        end
                    end
                    ACT_FIND:
                    begin
                        load_rsp = 1'b1;
                        rsp_hit  = any_match;
                    end
                    default:
                    begin
                        load_rsp = 1'b1;
                        rsp_hit  = any_match;
                    end
                endcase
            end
        end
        else
        begin
            if (any_match)
            begin
                ctrl.pull  = 1'b1;
                count_next = count_reg - CNT_W'(1);
            end
            else
            begin
                // no match left: report and return to idle
                load_rsp   = 1'b1;
                rsp_hit    = 1'b1;
                state_next = ST_IDLE;
            end
        end
    end

    assign count_ext = {{RSP_COUNT_W{1'b0}}, count_next};

    always_comb
    begin
        rsp_next          = rsp_reg;
        rsp_valid_next    = rsp_valid_reg;
        if (rsp_ready)
        begin
            rsp_valid_next = 1'b0;
        end
        if (load_rsp)
        begin
            rsp_valid_next    = 1'b1;
            rsp_next.hit      = rsp_hit;
            rsp_next.count    = count_ext[RSP_COUNT_W-1:0];
            rsp_next.overflow = rsp_ovf;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg <= key_next;
        rsp_reg <= rsp_next;
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    // Fill count never passes the depth.
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(LIST_DEPTH))
        else $error("fill count above list depth");

    // A dropped insert never reports a hit.
    a_ovf_no_hit: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid_reg && rsp_reg.overflow) |-> !rsp_reg.hit)
        else $error("overflow result with hit set");

    // The result register is free for the whole remove-all sweep.
    a_remall_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_REMALL) |-> !rsp_valid_reg)
        else $error("result pending during remove-all");

    // Each remove-all cycle either shrinks the list or ends the sweep.
    a_remall_progress: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_REMALL) |=>
            ((count_reg < $past(count_reg)) || (state_reg == ST_IDLE)))
        else $error("remove-all made no progress");

    // No request is taken while a sweep is running.
    a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
        req_ready |-> (state_reg == ST_IDLE))
        else $error("request ready outside idle");

endmodule
